FILE: rtl/bfpm_pkg.sv
// Package for the prefix-match Bloom filter: MurmurHash3 constants,
// shared types and the front-to-back command struct. No dependencies.
`default_nettype none
package bfpm_pkg;

  localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2 = 32'h1b873593;
  localparam logic [31:0] MM_N  = 32'he6546b64;
  localparam logic [31:0] MM_F1 = 32'h85ebca6b;
  localparam logic [31:0] MM_F2 = 32'hc2b2ae35;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_QUERY  = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CLEAR,
    BK_RUN,
    BK_DONE
  } bk_state_e;

  typedef struct packed {
    mode_e       mode;
    logic [31:0] address;
    logic [5:0]  pfx_len;
  } cmd_t;

endpackage
`default_nettype wire

FILE: rtl/bfpm_front.sv
// Front end: accepts items, drops invalid inserts, queues commands.
// Depends on bfpm_pkg.
`default_nettype none
module bfpm_front #(
  parameter int unsigned ADDRESS_BITS = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  output      logic            full_o,
  input  wire logic            mode_i,
  input  wire logic [31:0]     address_i,
  input  wire logic [5:0]      pfx_len_i,
  output      logic            cmd_valid_o,
  input  wire logic            cmd_take_i,
  output      bfpm_pkg::cmd_t  cmd_o
);

  localparam int unsigned QDEPTH = 2;

  bfpm_pkg::cmd_t q_mem [QDEPTH];
  logic           wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           xfer, keep;
  logic [31:0]    amask;

  assign amask  = 32'hffffffff >> (6'd32 - 6'(ADDRESS_BITS));
  assign full_o = (cnt_q == 2'(QDEPTH));
  assign xfer   = push_i && !full_o;
  assign keep   = xfer && (bfpm_pkg::mode_e'(mode_i) == bfpm_pkg::MODE_QUERY ||
                  (pfx_len_i != 6'd0 && pfx_len_i <= 6'(ADDRESS_BITS)));
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = keep ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = cmd_take_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(keep) - 2'(cmd_take_i);
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      q_mem[wr_ptr_q] <= '{mode: bfpm_pkg::mode_e'(mode_i),
                           address: address_i & amask,
                           pfx_len: pfx_len_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bfpm_hash.sv
// Pipelined MurmurHash3-32 of one word, one seed, five register stages.
// Depends on bfpm_pkg.
`default_nettype none
module bfpm_hash (
  input  wire logic        clk_i,
  input  wire logic [31:0] key_i,
  input  wire logic [31:0] seed_i,
  output      logic [31:0] hash_o
);

  logic [31:0] k1_q, seed1_q, h2_q, h3_q, h4_q, h5_q;
  logic [31:0] k1r, h2x, h2r, h3x, h4x;

  assign k1r = {k1_q[16:0], k1_q[31:17]};
  assign h2r = {h2x[18:0], h2x[31:19]};
  assign h3x = h3_q ^ (h3_q >> 16);
  assign h4x = h4_q ^ (h4_q >> 13);

  always_comb begin
    h2x = seed1_q ^ (k1r * bfpm_pkg::MM_C2);
  end

  always_ff @(posedge clk_i) begin
    k1_q    <= key_i * bfpm_pkg::MM_C1;
    seed1_q <= seed_i;
    h2_q    <= h2r;
    h3_q    <= (h2_q * 32'd5 + bfpm_pkg::MM_N) ^ 32'd4;
    h4_q    <= h3x * bfpm_pkg::MM_F1;
    h5_q    <= h4x * bfpm_pkg::MM_F2;
  end

  assign hash_o = h5_q ^ (h5_q >> 16);

endmodule
`default_nettype wire

FILE: rtl/bfpm_back.sv
// Back end: clears filters after reset, walks prefix lengths (query) or hashes
// (insert) through one hash pipe and one filter bank per hash, builds match vectors.
// Depends on bfpm_pkg and bfpm_hash.
`default_nettype none
module bfpm_back #(
  parameter int unsigned FILTER_BITS  = 1024,
  parameter int unsigned ADDRESS_BITS = 32,
  parameter int unsigned HASH_COUNT   = 3
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  output      logic           cmd_take_o,
  input  wire bfpm_pkg::cmd_t cmd_i,
  output      logic           res_valid_o,
  input  wire logic           res_take_i,
  output      logic [31:0]    res_o
);

  localparam int unsigned FW    = $clog2(FILTER_BITS);
  localparam int unsigned LW    = $clog2(ADDRESS_BITS);
  localparam int unsigned HW    = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;
  localparam int unsigned DEPTH = FILTER_BITS * ADDRESS_BITS;
  localparam int unsigned AW    = FW + LW;
  localparam int unsigned LAT   = 6;

  bfpm_pkg::bk_state_e state_q, state_d;
  logic [LW:0]    issue_q, issue_d;
  logic [LW:0]    done_q, done_d;
  logic [AW-1:0]  clr_q, clr_d;
  bfpm_pkg::cmd_t cmd_q;
  logic [31:0]    vec_q, vec_d;
  logic [31:0]    res_q;
  logic           res_v_q, res_v_d;
  logic [LAT-1:0] vld_q;
  logic [LW-1:0]  lp_q [LAT-1];
  logic           issue;
  logic [31:0]    key, keyd;
  logic [LW:0]    len;
  logic [LW-1:0]  lidx;
  logic [HASH_COUNT-1:0] rd_bit;
  logic           hit, last_rsp, rsp, wr, last_wr;
  logic [31:0]    hsel;
  logic [AW-1:0]  wa;

  assign len  = (cmd_q.mode == bfpm_pkg::MODE_QUERY) ? issue_q + 1'b1
                : cmd_q.pfx_len[LW:0];
  assign lidx = LW'(len - 1'b1);
  assign keyd = cmd_q.address >> (6'(ADDRESS_BITS) - 6'(len));
  assign key  = keyd;
  // insert: same key issued once per hash, each bank gets every hash bit
  assign issue = (state_q == bfpm_pkg::BK_RUN) &&
                 ((cmd_q.mode == bfpm_pkg::MODE_QUERY) ? (issue_q < (LW+1)'(ADDRESS_BITS))
                  : (issue_q < (LW+1)'(HASH_COUNT)));
  assign rsp  = vld_q[LAT-1] && (cmd_q.mode == bfpm_pkg::MODE_QUERY);
  assign wr   = vld_q[LAT-2] && (cmd_q.mode == bfpm_pkg::MODE_INSERT);
  assign hit  = &rd_bit;
  assign last_rsp = rsp && (done_q == (LW+1)'(ADDRESS_BITS - 1));
  assign last_wr  = wr && (done_q == (LW+1)'(HASH_COUNT - 1));

  logic [31:0] hv [HASH_COUNT];
  assign hsel = hv[done_q[HW-1:0]];
  assign wa   = {lp_q[LAT-2], hsel[FW-1:0]};

  for (genvar g = 0; g < HASH_COUNT; g++) begin : g_bank
    logic mem [DEPTH];
    logic [AW-1:0] a;
    logic rd_q;
    bfpm_hash u_hash (
      .clk_i  (clk_i),
      .key_i  (key),
      .seed_i (32'(g + 1)),
      .hash_o (hv[g])
    );
    assign a = {lp_q[LAT-2], hv[g][FW-1:0]};
    always_ff @(posedge clk_i) begin
      if (state_q == bfpm_pkg::BK_CLEAR) begin
        mem[clr_q] <= 1'b0;
      end else if (wr) begin
        mem[wa] <= 1'b1;
      end
      rd_q <= mem[a];
    end
    assign rd_bit[g] = rd_q;
  end

  always_ff @(posedge clk_i) begin
    lp_q[0] <= lidx;
    for (int i = 1; i < LAT - 1; i++) lp_q[i] <= lp_q[i-1];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bfpm_pkg::BK_CLEAR: if (clr_q == AW'(DEPTH - 1)) state_d = bfpm_pkg::BK_IDLE;
      bfpm_pkg::BK_IDLE:  if (cmd_valid_i && !res_v_q) state_d = bfpm_pkg::BK_RUN;
      bfpm_pkg::BK_RUN: begin
        if (cmd_q.mode == bfpm_pkg::MODE_INSERT ? last_wr : last_rsp)
          state_d = bfpm_pkg::BK_DONE;
      end
      bfpm_pkg::BK_DONE:  state_d = bfpm_pkg::BK_IDLE;
      default:            state_d = bfpm_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_take_o = (state_q == bfpm_pkg::BK_IDLE) && cmd_valid_i && !res_v_q;
    clr_d   = clr_q + 1'b1;
    issue_d = cmd_take_o ? '0 : (issue ? issue_q + 1'b1 : issue_q);
    done_d  = cmd_take_o ? '0 : ((rsp || wr) ? done_q + 1'b1 : done_q);
    vec_d   = cmd_take_o ? '0 : vec_q;
    if (rsp) vec_d[done_q[LW-1:0]] = hit;
    res_v_d = res_v_q;
    if (res_take_i) res_v_d = 1'b0;
    if (last_rsp)   res_v_d = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) cmd_q <= cmd_i;
    vec_q <= vec_d;
    if (last_rsp) res_q <= vec_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfpm_pkg::BK_CLEAR;
      clr_q   <= '0;
      issue_q <= '0;
      done_q  <= '0;
      vld_q   <= '0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      issue_q <= issue_d;
      done_q  <= done_d;
      vld_q   <= {vld_q[LAT-2:0], issue};
      res_v_q <= res_v_d;
    end
  end

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

FILE: rtl/bloom_filter_prefix_match.sv
// Prefix-match Bloom filter: one filter per prefix length, MurmurHash3.
// Insert: one hash issue and one bit write per hash in the back end.
// Query: one prefix length per cycle; the next item waits until the result
// is popped. Reset starts a clearing pass over all FILTER_BITS*ADDRESS_BITS
// bits of each bank, during which no item leaves the front queue.
`default_nettype none
module bloom_filter_prefix_match #(
  parameter int unsigned FILTER_BITS  = 1024,
  parameter int unsigned ADDRESS_BITS = 32,
  parameter int unsigned HASH_COUNT   = 3
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output      logic        full,
  input  wire logic        mode_i,
  input  wire logic [31:0] address_i,
  input  wire logic [5:0]  pfx_len_i,
  output      logic        empty,
  input  wire logic        pop,
  output      logic [31:0] match_vector_o
);

  logic           cmd_valid, cmd_take, res_valid;
  bfpm_pkg::cmd_t cmd;

  bfpm_front #(.ADDRESS_BITS(ADDRESS_BITS)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .mode_i, .address_i,
    .pfx_len_i, .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take), .cmd_o(cmd)
  );

  bfpm_back #(
    .FILTER_BITS(FILTER_BITS), .ADDRESS_BITS(ADDRESS_BITS), .HASH_COUNT(HASH_COUNT)
  ) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take), .cmd_i(cmd),
    .res_valid_o(res_valid), .res_take_i(pop && !empty), .res_o(match_vector_o)
  );

  assign empty = !res_valid;

  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take |-> cmd_valid) else $error("take from empty queue");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(match_vector_o)))
    else $error("result lost");

endmodule
`default_nettype wire
